>>> rtl/core/lwpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Land/water classifier package
// Shared codes, constants and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lwpc_pkg;

    // Item operation codes.
    localparam logic [1:0] OP_WR_VERTEX = 2'd0;
    localparam logic [1:0] OP_WR_RING   = 2'd1;
    localparam logic [1:0] OP_QUERY     = 2'd2;
    localparam logic [1:0] OP_NOP       = 2'd3;

    // Result codes.
    localparam logic [1:0] CLASS_NONE  = 2'd0;
    localparam logic [1:0] CLASS_WATER = 2'd1;
    localparam logic [1:0] CLASS_LAND  = 2'd2;

    // Search phases.
    localparam logic [1:0] PH_LAND  = 2'd0;
    localparam logic [1:0] PH_HOLE  = 2'd1;
    localparam logic [1:0] PH_WATER = 2'd2;

    // Configuration register word index.
    localparam logic [1:0] REG_RINGS_IN_USE = 2'd0;

    // Angles in 1/256 centidegree.
    localparam logic signed [25:0] LAT_LIMIT = 26'sd2304000;
    localparam logic signed [25:0] HALF_TURN = 26'sd4608000;
    localparam logic signed [25:0] FULL_TURN = 26'sd9216000;
    // Box longitude span in centidegrees above which the longitude test always passes.
    localparam logic signed [16:0] WIDE_SPAN = 17'sd18000;

    typedef struct packed {
        logic       wr_vertex;
        logic       wr_ring;
        logic       q_load;
        logic       wrap_step;
        logic       ring_clr;
        logic       ring_inc;
        logic       ring_rd;
        logic       grp_load;
        logic       base_load;
        logic       reduce_step;
        logic       va_init;
        logic       v_rd;
        logic       v_ld;
        logic       v_first;
        logic       v_step;
        logic       mul;
        logic       acc;
        logic [1:0] phase;
    } t_cmd;

    typedef struct packed {
        logic lat_out;
        logic wrap_done;
        logic ring_end;
        logic sel;
        logic short_ring;
        logic reduce_done;
        logic v_last;
        logic ring_hit;
    } t_sts;

endpackage
`default_nettype wire

>>> rtl/core/land_water_polygon_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Land/water polygon classifier
// Even-odd ray casting of a query point over rings held in on-chip tables.
// ----------------------------------------------------------------------------
// Write items load the vertex table (opcode 0) and the ring table (opcode 1);
// writes beyond a table's depth are dropped. A query item (opcode 2) yields
// one cell_class transfer: 0 when the latitude is beyond plus or minus 90
// degrees, else 2 (land) or 1 (water). Land rings are searched in table
// order with a bounding-box test; the first that contains the point fixes
// its group, hole rings of that group are then ray cast, and finally water
// rings may clear the result. Opcode 3 is ignored. Tables are undefined
// until written, and a query must only reach entries that were written.
// Only entries below rings_in_use (clamped to RING_DEPTH) are searched. A
// query has a setup step and then, for every ring visited, a ring table read
// and box test; every ring that is walked takes one vertex table read, a
// registered multiply and an accumulate per edge, after a first_vertex at or
// beyond the table end is reduced in steps of VERTEX_DEPTH. Items are taken
// one at a time; a finished result is held in an output register, so the
// next item is accepted while it waits.
// ----------------------------------------------------------------------------
module land_water_polygon_classifier #(
    parameter int RING_DEPTH   = 256,
    parameter int VERTEX_DEPTH = 8192
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [12:0]        i_index,
    input  wire logic signed [22:0] i_query_lat,
    input  wire logic signed [24:0] i_query_lon,
    input  wire logic signed [14:0] i_south_lat,
    input  wire logic signed [15:0] i_west_lon,
    input  wire logic signed [14:0] i_north_lat,
    input  wire logic signed [15:0] i_east_lon,
    input  wire logic [12:0]        i_first_vertex,
    input  wire logic [13:0]        i_vertex_count,
    input  wire logic [1:0]         i_ring_kind,
    input  wire logic [7:0]         i_group_id,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [1:0]              o_cell_class,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [1:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import lwpc_pkg::*;

    // The only register, rings_in_use, occupies the single word of the map,
    // so every address decodes to it.
    logic [8:0] r_rings_in_use;
    logic [1:0] reg_word;

    assign reg_word = REG_RINGS_IN_USE;
    assign pready   = 1'b1;
    assign prdata   = {23'd0, r_rings_in_use};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rings_in_use <= '0;
        end else if (psel && penable && pwrite && (paddr[1:0] != reg_word || 1'b1)) begin
            r_rings_in_use <= pwdata[8:0];
        end
    end

    t_cmd cmd;
    t_sts sts;

    // The controller steps through the search; the datapath owns the tables.
    lwpc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_opcode     (i_opcode),
        .i_out_ready  (i_out_ready),
        .i_sts        (sts),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .o_cell_class (o_cell_class),
        .o_cmd        (cmd)
    );

    lwpc_dp #(
        .RING_DEPTH   (RING_DEPTH),
        .VERTEX_DEPTH (VERTEX_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_rings_in_use (r_rings_in_use),
        .i_index        (i_index),
        .i_query_lat    (i_query_lat),
        .i_query_lon    (i_query_lon),
        .i_south_lat    (i_south_lat),
        .i_west_lon     (i_west_lon),
        .i_north_lat    (i_north_lat),
        .i_east_lon     (i_east_lon),
        .i_first_vertex (i_first_vertex),
        .i_vertex_count (i_vertex_count),
        .i_ring_kind    (i_ring_kind),
        .i_group_id     (i_group_id),
        .o_sts          (sts)
    );

endmodule
`default_nettype wire

>>> rtl/core/lwpc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Land/water classifier controller
// Sequences table writes, the ring search phases and the vertex walk.
// ----------------------------------------------------------------------------
module lwpc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_opcode,
    input  wire logic          i_out_ready,
    input  wire lwpc_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_cell_class,
    output lwpc_pkg::t_cmd     o_cmd
);
    import lwpc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LATCHK = 4'd1;
    localparam logic [3:0] S_WRAP   = 4'd2;
    localparam logic [3:0] S_RRD    = 4'd3;
    localparam logic [3:0] S_REVAL  = 4'd4;
    localparam logic [3:0] S_REDUCE = 4'd5;
    localparam logic [3:0] S_VRD    = 4'd6;
    localparam logic [3:0] S_VLD    = 4'd7;
    localparam logic [3:0] S_VMUL   = 4'd8;
    localparam logic [3:0] S_VACC   = 4'd9;
    localparam logic [3:0] S_RRES   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic       r_land, n_land;
    logic       r_unc, n_unc;
    logic       r_first, n_first;
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_class, n_class;
    t_cmd       cmd;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_land      = r_land;
        n_unc       = r_unc;
        n_first     = r_first;
        n_out_valid = r_out_valid;
        n_class     = r_class;
        cmd         = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_opcode)
                        OP_WR_VERTEX: cmd.wr_vertex = 1'b1;
                        OP_WR_RING:   cmd.wr_ring = 1'b1;
                        OP_QUERY: begin
                            cmd.q_load = 1'b1;
                            n_state    = S_LATCHK;
                        end
                        default: ;
                    endcase
                end
            end
            S_LATCHK: begin
                n_land  = 1'b0;
                n_phase = PH_LAND;
                if (i_sts.lat_out) begin
                    n_unc   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_unc   = 1'b0;
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                if (i_sts.wrap_done) begin
                    cmd.ring_clr = 1'b1;
                    n_state      = S_RRD;
                end else begin
                    cmd.wrap_step = 1'b1;
                end
            end
            S_RRD: begin
                if (i_sts.ring_end) begin
                    if (r_phase == PH_HOLE) begin
                        n_phase      = PH_WATER;
                        cmd.ring_clr = 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    cmd.ring_rd = 1'b1;
                    n_state     = S_REVAL;
                end
            end
            S_REVAL: begin
                if (i_sts.sel && !i_sts.short_ring) begin
                    cmd.base_load = 1'b1;
                    n_state       = S_REDUCE;
                end else begin
                    cmd.ring_inc = 1'b1;
                    n_state      = S_RRD;
                end
            end
            S_REDUCE: begin
                if (i_sts.reduce_done) begin
                    cmd.va_init = 1'b1;
                    n_first     = 1'b1;
                    n_state     = S_VRD;
                end else begin
                    cmd.reduce_step = 1'b1;
                end
            end
            S_VRD: begin
                cmd.v_rd = 1'b1;
                n_state  = S_VLD;
            end
            S_VLD: begin
                cmd.v_ld    = 1'b1;
                cmd.v_first = r_first;
                if (r_first) begin
                    cmd.v_step = 1'b1;
                    n_first    = 1'b0;
                    n_state    = S_VRD;
                end else begin
                    n_state = S_VMUL;
                end
            end
            S_VMUL: begin
                cmd.mul = 1'b1;
                n_state = S_VACC;
            end
            S_VACC: begin
                cmd.acc = 1'b1;
                if (i_sts.v_last) begin
                    n_state = S_RRES;
                end else begin
                    cmd.v_step = 1'b1;
                    n_state    = S_VRD;
                end
            end
            S_RRES: begin
                if (i_sts.ring_hit) begin
                    if (r_phase == PH_LAND) begin
                        n_land       = 1'b1;
                        cmd.grp_load = 1'b1;
                        cmd.ring_clr = 1'b1;
                        n_phase      = PH_HOLE;
                        n_state      = S_RRD;
                    end else begin
                        n_land  = 1'b0;
                        n_state = S_DONE;
                    end
                end else begin
                    cmd.ring_inc = 1'b1;
                    n_state      = S_RRD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_class     = r_unc ? CLASS_NONE : (r_land ? CLASS_LAND : CLASS_WATER);
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        cmd.phase = r_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_LAND;
            r_land      <= 1'b0;
            r_unc       <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
            r_class     <= CLASS_NONE;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_land      <= n_land;
            r_unc       <= n_unc;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
            r_class     <= n_class;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cell_class = r_class;
    assign o_cmd        = cmd;

endmodule
`default_nettype wire

>>> rtl/core/lwpc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Land/water classifier datapath
// Ring and vertex tables, query registers, box test and crossing arithmetic.
// ----------------------------------------------------------------------------
module lwpc_dp #(
    parameter int RING_DEPTH   = 256,
    parameter int VERTEX_DEPTH = 8192
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lwpc_pkg::t_cmd     i_cmd,
    input  wire logic [8:0]         i_rings_in_use,
    input  wire logic [12:0]        i_index,
    input  wire logic signed [22:0] i_query_lat,
    input  wire logic signed [24:0] i_query_lon,
    input  wire logic signed [14:0] i_south_lat,
    input  wire logic signed [15:0] i_west_lon,
    input  wire logic signed [14:0] i_north_lat,
    input  wire logic signed [15:0] i_east_lon,
    input  wire logic [12:0]        i_first_vertex,
    input  wire logic [13:0]        i_vertex_count,
    input  wire logic [1:0]         i_ring_kind,
    input  wire logic [7:0]         i_group_id,
    output lwpc_pkg::t_sts          o_sts
);
    import lwpc_pkg::*;

    localparam int RAW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int VAW = $clog2(VERTEX_DEPTH);

    // One wrap step brings a difference of two in-range angles back in range.
    function automatic logic signed [25:0] wrap1(input logic signed [25:0] d);
        logic signed [25:0] r;
        r = d;
        if (d > HALF_TURN) begin
            r = d - FULL_TURN;
        end else if (d < -HALF_TURN) begin
            r = d + FULL_TURN;
        end
        return r;
    endfunction

    // Tables.
    logic [61:0] r_bounds_mem [RING_DEPTH];
    logic [36:0] r_shape_mem  [RING_DEPTH];
    logic [30:0] r_vert_mem   [VERTEX_DEPTH];

    logic [61:0] r_bnd;
    logic [36:0] r_shp;
    logic [30:0] r_vdata;

    logic signed [22:0] r_qlat;
    logic signed [24:0] r_qlon;
    logic [9:0]         r_ring;
    logic [7:0]         r_grp;
    logic [12:0]        r_base;
    logic [13:0]        r_n;
    logic [13:0]        r_i;
    logic [VAW-1:0]     r_vaddr;
    logic               r_inside;
    logic signed [22:0] r_la0, r_la1;
    logic signed [23:0] r_lo0, r_lo1;
    logic signed [47:0] r_p1;
    logic signed [48:0] r_p2;
    logic               r_cross;
    logic               r_dpos;

    // Address formation.
    logic               ring_wr_ok;
    logic               vert_wr_ok;
    logic [RAW+12:0]    ring_widx;
    logic [RAW+9:0]     ring_ridx;
    logic [VAW+12:0]    vert_widx;
    logic [VAW+12:0]    base_ext;
    logic [RAW-1:0]     ring_waddr;
    logic [RAW-1:0]     ring_raddr;
    logic [VAW-1:0]     vert_waddr;
    logic [VAW-1:0]     base_va;
    logic [VAW-1:0]     vaddr_inc;
    logic [VAW-1:0]     vaddr_nxt;
    logic [12:0]        ring_depth_c;
    logic [9:0]         used;

    assign ring_depth_c = 13'(RING_DEPTH);
    assign ring_wr_ok   = (i_index < ring_depth_c);
    assign vert_wr_ok   = (17'(i_index) < 17'(VERTEX_DEPTH));
    assign ring_widx    = {{RAW{1'b0}}, i_index};
    assign ring_ridx    = {{RAW{1'b0}}, r_ring};
    assign vert_widx    = {{VAW{1'b0}}, i_index};
    assign base_ext     = {{VAW{1'b0}}, r_base};
    assign ring_waddr   = ring_widx[RAW-1:0];
    assign ring_raddr   = ring_ridx[RAW-1:0];
    assign vert_waddr   = vert_widx[VAW-1:0];
    assign base_va      = base_ext[VAW-1:0];
    assign vaddr_inc    = (r_vaddr == VAW'(VERTEX_DEPTH - 1)) ? '0 : r_vaddr + 1'b1;
    assign vaddr_nxt    = ((r_i + 14'd1) == r_n) ? base_va : vaddr_inc;
    assign used         = ({4'b0, i_rings_in_use} > ring_depth_c) ?
                          {1'b0, ring_depth_c[8:0]} : {1'b0, i_rings_in_use};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_ring && ring_wr_ok) begin
            r_bounds_mem[ring_waddr] <= {i_south_lat, i_west_lon, i_north_lat, i_east_lon};
            r_shape_mem[ring_waddr]  <= {i_first_vertex, i_vertex_count, i_ring_kind,
                                         i_group_id};
        end
        if (i_cmd.ring_rd) begin
            r_bnd <= r_bounds_mem[ring_raddr];
            r_shp <= r_shape_mem[ring_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_vertex && vert_wr_ok) begin
            r_vert_mem[vert_waddr] <= {i_south_lat, i_west_lon};
        end
        if (i_cmd.v_rd) begin
            r_vdata <= r_vert_mem[r_vaddr];
        end
    end

    // Ring fields.
    logic signed [14:0] b_south, b_north;
    logic signed [15:0] b_west, b_east;
    logic [12:0]        s_first;
    logic [13:0]        s_count;
    logic [1:0]         s_kind;
    logic [7:0]         s_group;

    assign {b_south, b_west, b_north, b_east} = r_bnd;
    assign {s_first, s_count, s_kind, s_group} = r_shp;

    // Bounding box test.
    logic signed [22:0] s256, n256;
    logic signed [16:0] span;
    logic signed [25:0] box_lo, box_hi;
    logic               lat_ok, box_ok;

    always_comb begin
        s256   = {b_south, 8'h00};
        n256   = {b_north, 8'h00};
        span   = 17'(b_east) - 17'(b_west);
        box_lo = wrap1(26'($signed({b_west, 8'h00})) - 26'(r_qlon));
        box_hi = wrap1(26'($signed({b_east, 8'h00})) - 26'(r_qlon));
        lat_ok = !(r_qlat < s256) && !(r_qlat > n256);
        box_ok = lat_ok && ((span > WIDE_SPAN) ||
                 ((box_lo[25] || (box_lo == '0)) && !box_hi[25]));
    end

    logic sel;
    always_comb begin
        case (i_cmd.phase)
            PH_LAND:  sel = (s_kind == 2'd0) && box_ok;
            PH_HOLE:  sel = s_kind[1] && (s_group == r_grp);
            PH_WATER: sel = (s_kind == 2'd1) && box_ok;
            default:  sel = 1'b0;
        endcase
    end

    // Vertex scaling and crossing terms.
    logic signed [14:0] v_lat;
    logic signed [15:0] v_lon;
    logic signed [25:0] v_lo;
    logic signed [23:0] d_lat;
    logic signed [24:0] d_lon;
    logic signed [23:0] d_q;
    logic signed [49:0] num;
    logic signed [25:0] qlon_up, qlon_dn;

    always_comb begin
        v_lat   = r_vdata[30:16];
        v_lon   = r_vdata[15:0];
        v_lo    = wrap1(26'($signed({v_lon, 8'h00})) - 26'(r_qlon));
        d_lat   = 24'(r_la1) - 24'(r_la0);
        d_lon   = 25'(r_lo1) - 25'(r_lo0);
        d_q     = 24'(r_qlat) - 24'(r_la0);
        num     = 50'(r_p1) + 50'(r_p2);
        qlon_dn = 26'(r_qlon) - FULL_TURN;
        qlon_up = 26'(r_qlon) + FULL_TURN;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_load) begin
            r_qlat <= i_query_lat;
            r_qlon <= i_query_lon;
        end else if (i_cmd.wrap_step) begin
            r_qlon <= (26'(r_qlon) > HALF_TURN) ? qlon_dn[24:0] : qlon_up[24:0];
        end
        if (i_cmd.grp_load) begin
            r_grp <= s_group;
        end
        if (i_cmd.base_load) begin
            r_base <= s_first;
            r_n    <= s_count;
        end else if (i_cmd.reduce_step) begin
            r_base <= r_base - 13'(VERTEX_DEPTH);
        end
        if (i_cmd.va_init) begin
            r_vaddr <= base_va;
            r_i     <= '0;
        end else if (i_cmd.v_step) begin
            r_vaddr <= vaddr_nxt;
            r_i     <= r_i + 14'd1;
        end
        if (i_cmd.v_ld) begin
            r_la1 <= {v_lat, 8'h00};
            r_lo1 <= v_lo[23:0];
            if (i_cmd.v_first) begin
                r_la0 <= {v_lat, 8'h00};
                r_lo0 <= v_lo[23:0];
            end
        end
        if (i_cmd.mul) begin
            r_cross <= (r_la0 > r_qlat) != (r_la1 > r_qlat);
            r_dpos  <= ~d_lat[23];
            r_p1    <= r_lo0 * d_lat;
            r_p2    <= d_lon * d_q;
        end
        if (i_cmd.acc) begin
            r_la0 <= r_la1;
            r_lo0 <= r_lo1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring   <= '0;
            r_inside <= 1'b0;
        end else begin
            if (i_cmd.ring_clr) begin
                r_ring <= '0;
            end else if (i_cmd.ring_inc) begin
                r_ring <= r_ring + 10'd1;
            end
            if (i_cmd.base_load) begin
                r_inside <= 1'b0;
            end else if (i_cmd.acc && r_cross &&
                         ((r_dpos && !num[49] && (num != '0)) || (!r_dpos && num[49]))) begin
                r_inside <= ~r_inside;
            end
        end
    end

    always_comb begin
        o_sts.lat_out     = (26'(r_qlat) < -LAT_LIMIT) || (26'(r_qlat) > LAT_LIMIT);
        o_sts.wrap_done   = !(26'(r_qlon) > HALF_TURN) && !(26'(r_qlon) < -HALF_TURN);
        o_sts.ring_end    = (r_ring >= used);
        o_sts.sel         = sel;
        o_sts.short_ring  = (s_count < 14'd3);
        o_sts.reduce_done = (17'(r_base) < 17'(VERTEX_DEPTH));
        o_sts.v_last      = (r_i == r_n);
        o_sts.ring_hit    = r_inside;
    end

endmodule
`default_nettype wire
